// ----- sv/gps_jump_plausibility_monitor_unit_defines.svh -----
// assertion macros for the gps jump plausibility monitor
`ifndef GPS_JUMP_PLAUSIBILITY_MONITOR_UNIT_DEFINES_SVH
`define GPS_JUMP_PLAUSIBILITY_MONITOR_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define GJPM_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define GJPM_ASSERT_NXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// ----- sv/gjpm_pkg.sv -----
// types, constants and microcode rom of the gps jump plausibility monitor
package gjpm_pkg;

  localparam int POS_W      = 35;
  localparam int DIFF_W     = 36;
  localparam int TIME_W     = 40;
  localparam int DT_W       = 41;
  localparam int MS_W       = 10;
  localparam int LIM_W      = 6;
  localparam int MUL_W      = 25;
  localparam int PROD_W     = 50;
  localparam int R_W        = 50;
  localparam int ACC_W      = 102;
  localparam int STEP_W     = 5;
  localparam int WT_W       = 2;
  localparam int OUT_SUM_W  = 5;
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANOMALY_LIMIT = 1'b1;

  localparam logic [MS_W-1:0]  MAX_SPEED_RST     = 10'd30;
  localparam logic [LIM_W-1:0] ANOMALY_LIMIT_RST = 6'd3;

  localparam logic [STEP_W-1:0] STEP_DIFF   = 5'd0;
  localparam logic [STEP_W-1:0] STEP_SPEED  = 5'd14;
  localparam logic [STEP_W-1:0] STEP_STILL  = 5'd15;
  localparam logic [STEP_W-1:0] STEP_COMMIT = 5'd16;

  typedef enum logic [3:0] {
    SRC_ZERO, SRC_MS, SRC_DT_LO, SRC_DT_HI, SRC_DX_LO, SRC_DX_HI,
    SRC_DY_LO, SRC_DY_HI, SRC_R_LO, SRC_R_HI
  } mul_src_t;

  typedef enum logic [2:0] {
    ACC_NONE, ACC_LOAD, ACC_ADD, ACC_SUB, ACC_R_LOAD, ACC_R_ADD
  } acc_op_t;

  typedef enum logic [1:0] {SH_0, SH_25, SH_26, SH_50} shift_t;

  typedef enum logic [2:0] {
    ACT_NONE, ACT_DIFF, ACT_ABS, ACT_SPEED, ACT_STILL, ACT_COMMIT
  } act_t;

  typedef enum logic [1:0] {JMP_NEXT, JMP_IF_FIRST, JMP_IF_NONPOS, JMP_ALWAYS} jump_t;

  typedef struct packed {
    mul_src_t              src_a;
    mul_src_t              src_b;
    acc_op_t               acc_op;
    shift_t                shift;
    act_t                  act;
    jump_t                 jump;
    logic [STEP_W-1:0]     target;
  } ucode_t;

  typedef struct packed {
    logic first;
    logic nonpos;
  } status_t;

  function automatic ucode_t uword(input mul_src_t a, input mul_src_t b, input acc_op_t op,
                                   input shift_t sh, input act_t act, input jump_t jmp,
                                   input logic [STEP_W-1:0] tgt);
    ucode_t w;
    w.src_a  = a;
    w.src_b  = b;
    w.acc_op = op;
    w.shift  = sh;
    w.act    = act;
    w.jump   = jmp;
    w.target = tgt;
    return w;
  endfunction

  // product of step k is accumulated in step k+1
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    unique case (step)
      5'd0:  w = uword(SRC_ZERO,  SRC_ZERO,  ACC_NONE,   SH_0,  ACT_DIFF,   JMP_IF_FIRST,
                       STEP_COMMIT);
      5'd1:  w = uword(SRC_ZERO,  SRC_ZERO,  ACC_NONE,   SH_0,  ACT_ABS,    JMP_IF_NONPOS,
                       STEP_STILL);
      5'd2:  w = uword(SRC_MS,    SRC_DT_LO, ACC_NONE,   SH_0,  ACT_NONE,   JMP_NEXT, '0);
      5'd3:  w = uword(SRC_MS,    SRC_DT_HI, ACC_R_LOAD, SH_0,  ACT_NONE,   JMP_NEXT, '0);
      5'd4:  w = uword(SRC_DX_LO, SRC_DX_LO, ACC_R_ADD,  SH_25, ACT_NONE,   JMP_NEXT, '0);
      5'd5:  w = uword(SRC_DX_LO, SRC_DX_HI, ACC_LOAD,   SH_0,  ACT_NONE,   JMP_NEXT, '0);
      5'd6:  w = uword(SRC_DX_HI, SRC_DX_HI, ACC_ADD,    SH_26, ACT_NONE,   JMP_NEXT, '0);
      5'd7:  w = uword(SRC_DY_LO, SRC_DY_LO, ACC_ADD,    SH_50, ACT_NONE,   JMP_NEXT, '0);
      5'd8:  w = uword(SRC_DY_LO, SRC_DY_HI, ACC_ADD,    SH_0,  ACT_NONE,   JMP_NEXT, '0);
      5'd9:  w = uword(SRC_DY_HI, SRC_DY_HI, ACC_ADD,    SH_26, ACT_NONE,   JMP_NEXT, '0);
      5'd10: w = uword(SRC_R_LO,  SRC_R_LO,  ACC_ADD,    SH_50, ACT_NONE,   JMP_NEXT, '0);
      5'd11: w = uword(SRC_R_LO,  SRC_R_HI,  ACC_SUB,    SH_0,  ACT_NONE,   JMP_NEXT, '0);
      5'd12: w = uword(SRC_R_HI,  SRC_R_HI,  ACC_SUB,    SH_26, ACT_NONE,   JMP_NEXT, '0);
      5'd13: w = uword(SRC_ZERO,  SRC_ZERO,  ACC_SUB,    SH_50, ACT_NONE,   JMP_NEXT, '0);
      5'd14: w = uword(SRC_ZERO,  SRC_ZERO,  ACC_NONE,   SH_0,  ACT_SPEED,  JMP_ALWAYS,
                       STEP_COMMIT);
      5'd15: w = uword(SRC_ZERO,  SRC_ZERO,  ACC_NONE,   SH_0,  ACT_STILL,  JMP_NEXT, '0);
      5'd16: w = uword(SRC_ZERO,  SRC_ZERO,  ACC_NONE,   SH_0,  ACT_COMMIT, JMP_NEXT, '0);
      default: w = uword(SRC_ZERO, SRC_ZERO, ACC_NONE,   SH_0,  ACT_NONE,   JMP_ALWAYS,
                         STEP_COMMIT);
    endcase
    return w;
  endfunction

endpackage

// ----- sv/gjpm_seq.sv -----
// microcode sequencer: step counter, control rom and conditional jumps
module gjpm_seq (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   stall,
  input  gjpm_pkg::status_t      status,
  output gjpm_pkg::ucode_t       ctrl,
  output logic                   busy
);

  logic [gjpm_pkg::STEP_W-1:0] step;
  logic [gjpm_pkg::STEP_W-1:0] step_next;

  assign ctrl = gjpm_pkg::ucode_rom(step);

  always_comb begin
    unique case (ctrl.jump)
      gjpm_pkg::JMP_NEXT:      step_next = step + 1'b1;
      gjpm_pkg::JMP_IF_FIRST:  step_next = status.first ? ctrl.target : step + 1'b1;
      gjpm_pkg::JMP_IF_NONPOS: step_next = status.nonpos ? ctrl.target : step + 1'b1;
      gjpm_pkg::JMP_ALWAYS:    step_next = ctrl.target;
      default:                 step_next = step + 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= gjpm_pkg::STEP_DIFF;
    end else if (start) begin
      busy <= 1'b1;
      step <= gjpm_pkg::STEP_DIFF;
    end else if (busy && !stall) begin
      if (ctrl.act == gjpm_pkg::ACT_COMMIT) begin
        busy <= 1'b0;
      end else begin
        step <= step_next;
      end
    end
  end

endmodule

// ----- sv/gjpm_datapath.sv -----
// datapath: fix registers, differences, shared 25x25 multiplier and accumulators
module gjpm_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              run,
  input  gjpm_pkg::ucode_t                  ctrl,
  input  logic [gjpm_pkg::MS_W-1:0]         max_speed,
  input  logic signed [gjpm_pkg::POS_W-1:0] fix_x,
  input  logic signed [gjpm_pkg::POS_W-1:0] fix_y,
  input  logic [gjpm_pkg::TIME_W-1:0]       fix_time,
  output logic                              nonpos,
  output logic [gjpm_pkg::WT_W-1:0]         weight
);

  logic signed [gjpm_pkg::POS_W-1:0]  in_x, in_y, last_x, last_y;
  logic [gjpm_pkg::TIME_W-1:0]        in_t, last_t;
  logic signed [gjpm_pkg::DIFF_W-1:0] dx_d, dy_d;
  logic [gjpm_pkg::DT_W-1:0]          dt_d;
  logic [gjpm_pkg::POS_W-1:0]         dx, dy;
  logic [gjpm_pkg::R_W-1:0]           r;
  logic signed [gjpm_pkg::ACC_W-1:0]  acc;
  logic [gjpm_pkg::PROD_W-1:0]        prod;
  logic [gjpm_pkg::PROD_W-1:0]        prod_full;
  logic [gjpm_pkg::MUL_W-1:0]         op_a, op_b;
  logic [gjpm_pkg::ACC_W-1:0]         shifted;
  logic signed [gjpm_pkg::DIFF_W-1:0] dx_raw, dy_raw;
  logic [gjpm_pkg::DT_W-1:0]          dt_raw;

  assign nonpos = dt_d[gjpm_pkg::DT_W-1] || (dt_d == '0);

  assign dx_raw = {in_x[gjpm_pkg::POS_W-1], in_x} - {last_x[gjpm_pkg::POS_W-1], last_x};
  assign dy_raw = {in_y[gjpm_pkg::POS_W-1], in_y} - {last_y[gjpm_pkg::POS_W-1], last_y};
  assign dt_raw = {1'b0, in_t} - {1'b0, last_t};

  function automatic logic [gjpm_pkg::MUL_W-1:0] pick(input gjpm_pkg::mul_src_t s,
      input logic [gjpm_pkg::MS_W-1:0] ms, input logic [gjpm_pkg::DT_W-1:0] dt,
      input logic [gjpm_pkg::POS_W-1:0] ax, input logic [gjpm_pkg::POS_W-1:0] ay,
      input logic [gjpm_pkg::R_W-1:0] rr);
    logic [gjpm_pkg::MUL_W-1:0] v;
    case (s)
      gjpm_pkg::SRC_MS:    v = gjpm_pkg::MUL_W'(ms);
      gjpm_pkg::SRC_DT_LO: v = dt[24:0];
      gjpm_pkg::SRC_DT_HI: v = gjpm_pkg::MUL_W'(dt[39:25]);
      gjpm_pkg::SRC_DX_LO: v = ax[24:0];
      gjpm_pkg::SRC_DX_HI: v = gjpm_pkg::MUL_W'(ax[34:25]);
      gjpm_pkg::SRC_DY_LO: v = ay[24:0];
      gjpm_pkg::SRC_DY_HI: v = gjpm_pkg::MUL_W'(ay[34:25]);
      gjpm_pkg::SRC_R_LO:  v = rr[24:0];
      gjpm_pkg::SRC_R_HI:  v = rr[49:25];
      default:             v = '0;
    endcase
    return v;
  endfunction

  assign op_a      = pick(ctrl.src_a, max_speed, dt_d, dx, dy, r);
  assign op_b      = pick(ctrl.src_b, max_speed, dt_d, dx, dy, r);
  assign prod_full = gjpm_pkg::PROD_W'(op_a) * gjpm_pkg::PROD_W'(op_b);

  always_comb begin
    case (ctrl.shift)
      gjpm_pkg::SH_25: shifted = gjpm_pkg::ACC_W'(prod) << 25;
      gjpm_pkg::SH_26: shifted = gjpm_pkg::ACC_W'(prod) << 26;
      gjpm_pkg::SH_50: shifted = gjpm_pkg::ACC_W'(prod) << 50;
      default:         shifted = gjpm_pkg::ACC_W'(prod);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_x <= '0;
      last_y <= '0;
      last_t <= '0;
    end else if (run && ctrl.act == gjpm_pkg::ACT_COMMIT) begin
      last_x <= in_x;
      last_y <= in_y;
      last_t <= in_t;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      in_x <= fix_x;
      in_y <= fix_y;
      in_t <= fix_time;
    end
    if (run) begin
      prod <= prod_full;
      case (ctrl.act)
        gjpm_pkg::ACT_DIFF: begin
          dx_d <= dx_raw;
          dy_d <= dy_raw;
          dt_d <= dt_raw;
        end
        gjpm_pkg::ACT_ABS: begin
          dx <= dx_d[gjpm_pkg::DIFF_W-1] ? gjpm_pkg::POS_W'(-dx_d)
                                          : dx_d[gjpm_pkg::POS_W-1:0];
          dy <= dy_d[gjpm_pkg::DIFF_W-1] ? gjpm_pkg::POS_W'(-dy_d)
                                          : dy_d[gjpm_pkg::POS_W-1:0];
        end
        gjpm_pkg::ACT_SPEED: begin
          weight <= (!acc[gjpm_pkg::ACC_W-1] && (acc != '0)) ? 2'd1 : 2'd0;
        end
        gjpm_pkg::ACT_STILL: begin
          weight <= ((dt_d == '0) && ((dx_d != '0) || (dy_d != '0))) ? 2'd2 : 2'd1;
        end
        default: ;
      endcase
      case (ctrl.acc_op)
        gjpm_pkg::ACC_LOAD:   acc <= $signed(shifted);
        gjpm_pkg::ACC_ADD:    acc <= acc + $signed(shifted);
        gjpm_pkg::ACC_SUB:    acc <= acc - $signed(shifted);
        gjpm_pkg::ACC_R_LOAD: r   <= shifted[gjpm_pkg::R_W-1:0];
        gjpm_pkg::ACC_R_ADD:  r   <= r + shifted[gjpm_pkg::R_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/gps_jump_plausibility_monitor_unit.sv -----
// top level of the gps jump plausibility monitor
// Takes one fix per transfer and returns one result per fix, and takes a fix
// only when none is in flight. The first fix goes from its difference step
// straight to commit; a fix whose time step is zero or negative runs the
// magnitude and stationary steps before commit; any other fix runs the full
// speed test. The long path is set by the eleven partial products of the
// squared speed test running one per cycle through a single 25x25 multiplier
// under a microcode sequencer. The result sits in an output register, and a
// further fix is accepted while it waits; a finished fix holds in its last
// step until that register is free. Config writes can reach a fix in flight.
module gps_jump_plausibility_monitor_unit #(
  parameter int WINDOW_FIXES = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [gjpm_pkg::IN_DATA_W-1:0]       s_tdata,   // fix_x, fix_y, fix_time, zero pad
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [gjpm_pkg::OUT_DATA_W-1:0]      m_tdata,   // gps_normal, anomaly_sum, zero pad
  input  logic                                 cfg_we,
  input  logic [gjpm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gjpm_pkg::CFG_DATA_W-1:0]      cfg_data
);

`include "gps_jump_plausibility_monitor_unit_defines.svh"

  localparam int PAIRS  = WINDOW_FIXES - 1;
  localparam int SUM_W  = $clog2(2 * PAIRS + 1);
  localparam int CMP_W  = (SUM_W > 6) ? SUM_W : 6;
  localparam int SEEN_W = $clog2(WINDOW_FIXES + 1);
  localparam int PTR_W  = (PAIRS > 1) ? $clog2(PAIRS) : 1;

  logic [gjpm_pkg::MS_W-1:0]  max_speed;
  logic [gjpm_pkg::LIM_W-1:0] anomaly_limit;

  logic                       busy, start, stall, run, commit;
  gjpm_pkg::ucode_t           ctrl;
  gjpm_pkg::status_t          status;
  logic                       nonpos;
  logic [gjpm_pkg::WT_W-1:0]  weight;

  logic [SEEN_W-1:0]          fixes_seen, fixes_seen_next;
  logic [gjpm_pkg::WT_W-1:0]  pair_weights [PAIRS];
  logic [PTR_W-1:0]           ring_pointer;
  logic [SUM_W-1:0]           window_sum, window_sum_next;
  logic [CMP_W-1:0]           sum_ext;
  logic                       gps_normal;
  logic [gjpm_pkg::OUT_SUM_W-1:0] anomaly_sum;

  assign s_tready = !busy;
  assign start    = s_tvalid && s_tready;
  assign stall    = (ctrl.act == gjpm_pkg::ACT_COMMIT) && m_tvalid && !m_tready;
  assign run      = busy && !stall;
  assign commit   = run && (ctrl.act == gjpm_pkg::ACT_COMMIT);

  assign status.first  = (fixes_seen == '0);
  assign status.nonpos = nonpos;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed     <= gjpm_pkg::MAX_SPEED_RST;
      anomaly_limit <= gjpm_pkg::ANOMALY_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gjpm_pkg::CFG_MAX_SPEED:     max_speed     <= cfg_data;
        gjpm_pkg::CFG_ANOMALY_LIMIT: anomaly_limit <= cfg_data[gjpm_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  gjpm_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .stall  (stall),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  gjpm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .run       (run),
    .ctrl      (ctrl),
    .max_speed (max_speed),
    .fix_x     (s_tdata[34:0]),
    .fix_y     (s_tdata[69:35]),
    .fix_time  (s_tdata[109:70]),
    .nonpos    (nonpos),
    .weight    (weight)
  );

  always_comb begin
    window_sum_next = window_sum;
    if (!status.first) begin
      window_sum_next = window_sum - SUM_W'(pair_weights[ring_pointer]) + SUM_W'(weight);
    end
    fixes_seen_next = (fixes_seen < SEEN_W'(WINDOW_FIXES)) ? fixes_seen + 1'b1 : fixes_seen;
    sum_ext         = CMP_W'(window_sum_next);
    gps_normal      = (fixes_seen_next < SEEN_W'(2)) || (sum_ext < CMP_W'(anomaly_limit));
    anomaly_sum     = (sum_ext > CMP_W'(31)) ? 5'd31 : sum_ext[gjpm_pkg::OUT_SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fixes_seen   <= '0;
      ring_pointer <= '0;
      window_sum   <= '0;
      for (int i = 0; i < PAIRS; i++) begin
        pair_weights[i] <= '0;
      end
    end else if (commit) begin
      fixes_seen <= fixes_seen_next;
      window_sum <= window_sum_next;
      if (!status.first) begin
        pair_weights[ring_pointer] <= weight;
        ring_pointer <= (ring_pointer == PTR_W'(PAIRS - 1)) ? '0 : ring_pointer + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata <= {2'b00, anomaly_sum, gps_normal};
    end
  end

  `GJPM_ASSERT_NXT(a_busy_after_take, start, !s_tready, "fix taken while one is in flight")
  `GJPM_ASSERT_IMP(a_commit_slot, commit, !m_tvalid || m_tready, "result register overrun")
  `GJPM_ASSERT_NXT(a_commit_shows, commit, m_tvalid, "finished fix gave no result")
  `GJPM_ASSERT_IMP(a_sum_bound, 1'b1, window_sum <= SUM_W'(2 * PAIRS), "window sum out of range")

endmodule

// ----- dv/tb.sv -----
// testbench for the gps jump plausibility monitor: random and directed fixes against a scoreboard
`timescale 1ns / 100ps

module tb;

  localparam int POS_W      = gjpm_pkg::POS_W;
  localparam int TIME_W     = gjpm_pkg::TIME_W;
  localparam int MS_W       = gjpm_pkg::MS_W;
  localparam int LIM_W      = gjpm_pkg::LIM_W;
  localparam int OUT_SUM_W  = gjpm_pkg::OUT_SUM_W;
  localparam int IN_DATA_W  = gjpm_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = gjpm_pkg::OUT_DATA_W;
  localparam int CFG_IDX_W  = gjpm_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = gjpm_pkg::CFG_DATA_W;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED     = gjpm_pkg::CFG_MAX_SPEED;
  localparam logic [CFG_IDX_W-1:0] CFG_ANOMALY_LIMIT = gjpm_pkg::CFG_ANOMALY_LIMIT;
  localparam logic [MS_W-1:0]      MAX_SPEED_RST     = gjpm_pkg::MAX_SPEED_RST;
  localparam logic [LIM_W-1:0]     ANOMALY_LIMIT_RST = gjpm_pkg::ANOMALY_LIMIT_RST;

  localparam int WINDOW      = 16;
  localparam int PAIRS       = WINDOW - 1;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 3000;
  localparam int SETTLE      = 30;
  localparam int PER_SETTING = 78;

  localparam logic [POS_W-1:0]  POS_TOP    = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [POS_W-1:0]  POS_BOTTOM = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic [TIME_W-1:0] TIME_TOP   = '1;

  typedef struct packed {
    logic                 normal;
    logic [OUT_SUM_W-1:0] sum;
  } verdict_t;

  class plausibility_tracker;
    logic [MS_W-1:0]   speed_cap;
    logic [LIM_W-1:0]  sum_limit;
    logic [POS_W-1:0]  prev_x;
    logic [POS_W-1:0]  prev_y;
    logic [TIME_W-1:0] prev_t;
    int unsigned       fixes_held;
    logic [1:0]        weights [PAIRS];
    int unsigned       slot;
    int unsigned       sum_now;
    verdict_t          verdicts_due [$];
    int unsigned       mismatches;
    int unsigned       verdicts_seen;
    int unsigned       fixes_taken;
    int unsigned       weight_tally [3];

    function void clear();
      speed_cap  = MAX_SPEED_RST;
      sum_limit  = ANOMALY_LIMIT_RST;
      prev_x     = '0;
      prev_y     = '0;
      prev_t     = '0;
      fixes_held = 0;
      foreach (weights[i]) weights[i] = '0;
      slot       = 0;
      sum_now    = 0;
      verdicts_due.delete();
      mismatches = 0;
      verdicts_seen = 0;
      fixes_taken = 0;
      foreach (weight_tally[i]) weight_tally[i] = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_MAX_SPEED:     speed_cap = val[MS_W-1:0];
        CFG_ANOMALY_LIMIT: sum_limit = val[LIM_W-1:0];
        default: ;
      endcase
    endfunction

    // squared speed test without division
    function logic [1:0] pair_weight(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                     logic [TIME_W-1:0] t);
      logic signed [POS_W:0]  dx;
      logic signed [POS_W:0]  dy;
      logic [POS_W:0]         ax;
      logic [POS_W:0]         ay;
      logic signed [TIME_W+1:0] dt;
      logic [127:0]           dist_sq;
      logic [127:0]           span;
      dx = $signed({x[POS_W-1], x}) - $signed({prev_x[POS_W-1], prev_x});
      dy = $signed({y[POS_W-1], y}) - $signed({prev_y[POS_W-1], prev_y});
      ax = dx[POS_W] ? -dx : dx;
      ay = dy[POS_W] ? -dy : dy;
      dt = $signed({2'b00, t}) - $signed({2'b00, prev_t});
      if (dt <= 0) begin
        return (dt == 0 && (ax | ay) != 0) ? 2'd2 : 2'd1;
      end
      span    = 128'(speed_cap) * 128'(dt[TIME_W:0]);
      dist_sq = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
      return (dist_sq > span * span) ? 2'd1 : 2'd0;
    endfunction

    function void take_fix(logic [POS_W-1:0] x, logic [POS_W-1:0] y, logic [TIME_W-1:0] t);
      logic [1:0] w;
      verdict_t   v;
      fixes_taken++;
      if (fixes_held > 0) begin
        w = pair_weight(x, y, t);
        weight_tally[w]++;
        sum_now = sum_now - weights[slot] + w;
        weights[slot] = w;
        slot = (slot + 1) % PAIRS;
      end
      if (fixes_held < WINDOW) fixes_held++;
      prev_x = x;
      prev_y = y;
      prev_t = t;
      v.normal = (fixes_held < 2) || (sum_now < sum_limit);
      v.sum    = (sum_now > 31) ? 5'd31 : OUT_SUM_W'(sum_now);
      verdicts_due.insert(verdicts_due.size(), v);
    endfunction

    function void check_verdict(logic [OUT_DATA_W-1:0] word);
      verdict_t want;
      if (verdicts_due.size() == 0) begin
        $display("%0t: result with no fix pending: expected none, actual %h", $time, word);
        mismatches++;
        return;
      end
      want = verdicts_due[0];
      verdicts_due.delete(0);
      verdicts_seen++;
      if (word[0] !== want.normal) begin
        $display("%0t: gps_normal mismatch: expected %0b, actual %0b",
                 $time, want.normal, word[0]);
        mismatches++;
      end
      if (word[OUT_SUM_W:1] !== want.sum) begin
        $display("%0t: anomaly_sum mismatch: expected %0d, actual %0d",
                 $time, want.sum, word[OUT_SUM_W:1]);
        mismatches++;
      end
      if (word[OUT_DATA_W-1:OUT_SUM_W+1] !== '0) begin
        $display("%0t: result pad mismatch: expected 0, actual %b",
                 $time, word[OUT_DATA_W-1:OUT_SUM_W+1]);
        mismatches++;
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    s_tvalid;
  logic                    s_tready;
  logic [IN_DATA_W-1:0]    s_tdata;
  logic                    m_tvalid;
  logic                    m_tready;
  logic [OUT_DATA_W-1:0]   m_tdata;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  plausibility_tracker tracker;
  logic [POS_W-1:0]  offer_x;
  logic [POS_W-1:0]  offer_y;
  logic [TIME_W-1:0] offer_t;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          hold_on = 1'b0;
  int unsigned settings_used = 1;
  int unsigned quiet_cycles = 0;

  gps_jump_plausibility_monitor_unit #(.WINDOW_FIXES(WINDOW)) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_fix(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                          input logic [TIME_W-1:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W-2*POS_W-TIME_W){1'b0}}, t, y, x};
    offer_x = x;
    offer_y = y;
    offer_t = t;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.take_fix(x, y, t);
    @(negedge clk);
  endtask

  task automatic write_limits(input logic [MS_W-1:0] speed, input logic [LIM_W-1:0] lim);
    logic [CFG_DATA_W-1:0] lim_word;
    lim_word = CFG_DATA_W'($urandom);
    lim_word[LIM_W-1:0] = lim;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAX_SPEED;
    cfg_data  <= speed;
    @(negedge clk);
    cfg_index <= CFG_ANOMALY_LIMIT;
    cfg_data  <= lim_word;
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.set_reg(CFG_MAX_SPEED, speed);
    tracker.set_reg(CFG_ANOMALY_LIMIT, lim_word);
    settings_used++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (tracker.verdicts_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic directed_fixes();
    int unsigned i;
    send_fix(POS_W'(0), POS_W'(0), TIME_W'(1000));
    send_fix(POS_W'(0), POS_W'(0), TIME_W'(1000));
    send_fix(POS_W'(5), POS_W'(-7), TIME_W'(1000));
    send_fix(POS_W'(-100000), POS_W'(100000), TIME_W'(400));
    send_fix(POS_W'(-100000 + 3000), POS_W'(100000), TIME_W'(500));
    send_fix(POS_W'(-100000 + 6001), POS_W'(100000), TIME_W'(600));
    send_fix(POS_W'(-100000 + 7801), POS_W'(100000 + 2400), TIME_W'(700));
    send_fix(POS_TOP, POS_BOTTOM, TIME_TOP);
    send_fix(POS_BOTTOM, POS_TOP, TIME_W'(0));
    send_fix(POS_TOP, POS_BOTTOM, TIME_W'(1));
    // moving fixes with a frozen clock fill the window with the heaviest weight
    for (i = 0; i < PAIRS; i++) send_fix(POS_W'(i + 1), POS_W'(3 * i), TIME_W'(1));
  endtask

  task automatic random_fix();
    int unsigned       pick;
    int unsigned       step;
    int unsigned       reach;
    int                off_x;
    int                off_y;
    logic [POS_W-1:0]  rim;
    logic [POS_W-1:0]  nx;
    logic [POS_W-1:0]  ny;
    logic [TIME_W-1:0] nt;
    pick  = $urandom_range(99);
    step  = $urandom_range(1, 400);
    reach = tracker.speed_cap * step;
    off_x = int'($urandom_range(0, 2 * reach)) - int'(reach);
    off_y = int'($urandom_range(0, 3 * reach / 2)) - int'(3 * reach / 4);
    nx = offer_x + POS_W'(off_x);
    ny = offer_y + POS_W'(off_y);
    nt = offer_t + TIME_W'(step);
    if (pick < 8) begin
      nt = offer_t;
      if (pick < 4) begin
        nx = offer_x;
        ny = offer_y;
      end
    end else if (pick < 16) begin
      nt = offer_t - TIME_W'($urandom_range(1, 5000));
    end else if (pick < 24) begin
      nx = POS_W'({$urandom, $urandom});
      ny = POS_W'({$urandom, $urandom});
      nt = TIME_W'({$urandom, $urandom});
    end else if (pick < 34) begin
      // right at the speed bound or one millimetre past it
      rim = POS_W'(reach + $urandom_range(1));
      nx = offer_x;
      ny = offer_y;
      if ($urandom_range(1)) nx = $urandom_range(1) ? offer_x + rim : offer_x - rim;
      else ny = $urandom_range(1) ? offer_y + rim : offer_y - rim;
    end
    send_fix(nx, ny, nt);
  endtask

  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_on) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_on = 1'b0;
      end
      m_tready <= ($urandom_range(99) >= stall_pct);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_verdict(m_tdata);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("** gps_jump_plausibility_monitor_unit: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned s;
    int unsigned k;
    int unsigned send_plan [4];
    int unsigned stall_plan [4];
    int unsigned speed_plan [8];
    int unsigned lim_plan [8];
    send_plan  = '{0, 57, 0, 30};
    stall_plan = '{0, 0, 57, 30};
    speed_plan = '{30, 5, 0, 1023, 1, 200, 0, 0};
    lim_plan   = '{3, 2, 0, 63, 1, 8, 0, 0};
    tracker = new;
    tracker.clear();
    offer_x   = '0;
    offer_y   = '0;
    offer_t   = '0;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_MAX_SPEED;
    cfg_data  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    directed_fixes();
    for (s = 0; s < 8; s++) begin
      send_idle_pct = send_plan[s / 2];
      stall_pct     = stall_plan[s / 2];
      if (s != 0) begin
        drain();
        if (s >= 6) begin
          write_limits(MS_W'($urandom_range(1, 1023)), LIM_W'($urandom_range(1, 12)));
        end else begin
          write_limits(MS_W'(speed_plan[s]), LIM_W'(lim_plan[s]));
        end
      end
      for (k = 0; k < PER_SETTING; k++) begin
        if (s == 1 && k == 20) hold_on = 1'b1;
        random_fix();
      end
    end
    s_tvalid <= 1'b0;
    while (tracker.verdicts_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    $display("%0d fixes sent, %0d results checked, %0d register settings",
             tracker.fixes_taken, tracker.verdicts_seen, settings_used);
    $display("pairs scored 0/1/2: %0d/%0d/%0d, %0d mismatches",
             tracker.weight_tally[0], tracker.weight_tally[1], tracker.weight_tally[2],
             tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.verdicts_due.size() == 0) begin
      $display("** gps_jump_plausibility_monitor_unit: PASSED **");
    end else begin
      $display("** gps_jump_plausibility_monitor_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/gjpm_pkg.sv
sv/gjpm_seq.sv
sv/gjpm_datapath.sv
sv/gps_jump_plausibility_monitor_unit.sv
dv/tb.sv
